@@ rtl/ogru_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ogru_pkg: shared types and constants of the occupancy grid ray update core
// Holds the sequencer states, the multiplier request, the register indexes
// and the fixed-point constants of the beam trace.
// ---------------------------------------------------------------------------
package ogru_pkg;

    localparam int MAP_WIDTH_DEF  = 256;
    localparam int MAP_HEIGHT_DEF = 256;
    localparam int MAX_BEAMS_DEF  = 2048;
    localparam int TRIG_BITS_DEF  = 10;

    localparam int MUL_A_W = 27;
    localparam int MUL_B_W = 18;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam logic [2:0] CFG_CELLS_PER_METRE = 3'd0;
    localparam logic [2:0] CFG_ORIGIN_X        = 3'd1;
    localparam logic [2:0] CFG_ORIGIN_Y        = 3'd2;
    localparam logic [2:0] CFG_ANGLE_START     = 3'd3;
    localparam logic [2:0] CFG_ANGLE_STEP      = 3'd4;
    localparam logic [2:0] CFG_OCC_INCREMENT   = 3'd5;
    localparam logic [2:0] CFG_FREE_DECREMENT  = 3'd6;

    localparam logic signed [8:0] OCC_MAX    = 9'sd100;
    localparam logic signed [8:0] OCC_MIN    = 9'sd0;
    localparam logic signed [8:0] UNKNOWN_AS = 9'sd50;
    localparam logic signed [7:0] CELL_UNKNOWN = -8'sd1;
    localparam logic [15:0] MIN_RANGE = 16'd52;
    localparam logic [15:0] RANGE_CLAMP = 16'd10240;

    localparam logic [14:0] SIN_C1  = 15'd1231;
    localparam logic [14:0] SIN_C2  = 15'd10583;
    localparam logic [14:0] SIN_C3  = 15'd25736;
    localparam logic [15:0] QUARTER = 16'h4000;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DISPATCH,
        ST_READ_ADDR,
        ST_READ_DATA,
        ST_ANGLE,
        ST_ANGLE_SUM,
        ST_SQ,
        ST_T1,
        ST_T2,
        ST_T3,
        ST_T4,
        ST_T5,
        ST_CELL_MUL,
        ST_CELL_RES,
        ST_CHECK,
        ST_WALK_RD,
        ST_WALK_WR,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic                      en;
        logic signed [MUL_A_W-1:0] a;
        logic signed [MUL_B_W-1:0] b;
    } mul_req_t;

    // Signed division by 2**k that truncates toward zero.
    function automatic logic signed [MUL_P_W-1:0] div_pow2_trunc(
        input logic signed [MUL_P_W-1:0] p,
        input int                        k
    );
        logic signed [MUL_P_W-1:0] bias;
        bias = p[MUL_P_W-1] ? MUL_P_W'((64'd1 << k) - 64'd1) : '0;
        return (p + bias) >>> k;
    endfunction

endpackage
`default_nettype wire

@@ rtl/occupancy_grid_ray_update_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// occupancy_grid_ray_update_core: traces laser beams into an occupancy grid
// Sequence: a read command passes the dispatch, read-address, read-data
// and finish states before done pulses; a valid beam computes its angle,
// offsets and cell coordinates, then does one read and one write of the
// grid memory port per cell walked. Throughput: one item at a time; busy
// stays high until the result beat. Reset: the control and configuration
// registers take their reset values and a clearing pass then writes all
// MAP_WIDTH*MAP_HEIGHT cells to unknown while busy is high. Results cannot be stalled.
// ---------------------------------------------------------------------------
module occupancy_grid_ray_update_core
    import ogru_pkg::*;
#(
    parameter int MAP_WIDTH       = MAP_WIDTH_DEF,
    parameter int MAP_HEIGHT      = MAP_HEIGHT_DEF,
    parameter int MAX_BEAMS       = MAX_BEAMS_DEF,
    parameter int TRIG_TABLE_BITS = TRIG_BITS_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               cmd,
    input  wire logic signed [23:0] pose_x,
    input  wire logic signed [23:0] pose_y,
    input  wire logic [15:0]        pose_heading,
    input  wire logic [15:0]        beam_range,
    input  wire logic               range_invalid,
    input  wire logic [10:0]        beam_index,
    input  wire logic [7:0]         read_x,
    input  wire logic [7:0]         read_y,
    output logic                    done,
    output logic signed [7:0]       cell_value,
    output logic [8:0]              cells_updated,
    output logic                    endpoint_marked,
    output logic                    beam_traced,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [23:0]        cfg_data
);

    // Grid geometry. The walk addresses the memory incrementally, so only
    // the entry address of a beam and of a read needs a constant multiply.
    localparam int DEPTH = MAP_WIDTH * MAP_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int MAXD  = (MAP_WIDTH > MAP_HEIGHT) ? MAP_WIDTH : MAP_HEIGHT;
    localparam int CW    = $clog2(MAXD) + 3;
    localparam logic [15:0] ANG_MASK = 16'(16'hFFFF << (16 - TRIG_TABLE_BITS));

    // Configuration registers.
    logic [15:0]        cpm_reg;
    logic signed [23:0] origin_x_reg;
    logic signed [23:0] origin_y_reg;
    logic [15:0]        ang_start_reg;
    logic [15:0]        ang_step_reg;
    logic [6:0]         occ_inc_reg;
    logic [6:0]         free_dec_reg;

    // Control state.
    state_t           state_reg, state_next;
    logic [AW-1:0]    clr_reg;
    logic             done_reg, done_next;

    // Captured command beat.
    logic               cmd_reg;
    logic signed [23:0] pose_x_reg, pose_y_reg;
    logic [15:0]        heading_reg;
    logic [15:0]        range_reg, range_next;
    logic               invalid_reg;
    logic [10:0]        beam_reg;
    logic [7:0]         rx_reg, ry_reg;

    // Arithmetic sequence.
    logic [15:0]        ang_reg, ang_next;
    logic               axis_reg, axis_next;
    logic [14:0]        x2_reg, x2_next;
    logic signed [24:0] hx_reg, hx_next, hy_reg, hy_next;
    logic [1:0]         cidx_reg, cidx_next;
    logic signed [25:0] cell_reg [4];
    logic signed [25:0] cell_next [4];
    logic               hit_reg, hit_next;

    // Line walk.
    logic signed [CW-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [CW-1:0] x1_reg, x1_next, y1_reg, y1_next;
    logic signed [CW-1:0] dx_reg, dx_next, dy_reg, dy_next;
    logic signed [CW-1:0] err_reg, err_next;
    logic                 sxn_reg, sxn_next, syn_reg, syn_next;
    logic [AW-1:0]        addr_reg, addr_next;

    // Result fields.
    logic signed [7:0] res_cell_reg, res_cell_next;
    logic [8:0]        count_reg, count_next;
    logic              marked_reg, marked_next;
    logic              traced_reg, traced_next;

    // Grid memory.
    logic signed [7:0] grid_mem [DEPTH];
    logic signed [7:0] mem_q_reg;
    logic              mem_we;
    logic [AW-1:0]     mem_wa, mem_ra;
    logic signed [7:0] mem_wd;

    mul_req_t                  mul_req;
    logic signed [MUL_P_W-1:0] prod;
    logic signed [MUL_P_W-1:0] prod_sh14;

    ogru_mul u_mul
    (
        .clk  (clk),
        .req  (mul_req),
        .prod (prod)
    );

    function automatic logic cell_in_map(input logic signed [25:0] c, input int dim);
        return (c >= 26'sd0) && (c < $signed(26'(dim)));
    endfunction

    function automatic logic coord_in_map(input logic signed [CW-1:0] c, input int dim);
        return (c >= $signed(CW'(0))) && (c < $signed(CW'(dim)));
    endfunction

    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign prod_sh14 = prod >>> 14;

    // Quarter-wave argument: x uses the cosine, which is the sine a quarter
    // turn ahead, and y uses the sine.
    logic [15:0] trig_ang;
    logic [1:0]  quad;
    logic [14:0] q;
    assign trig_ang = axis_reg ? ang_reg : ang_reg + QUARTER;
    assign quad     = trig_ang[15:14];
    assign q        = quad[0] ? 15'(17'd16384 - {3'b0, trig_ang[13:0]})
                              : {1'b0, trig_ang[13:0]};

    // Read command address and bounds.
    logic          rd_in_map;
    logic [AW-1:0] rd_addr;
    assign rd_in_map = (32'(rx_reg) < 32'(MAP_WIDTH)) && (32'(ry_reg) < 32'(MAP_HEIGHT));
    assign rd_addr   = AW'(32'(ry_reg) * 32'(MAP_WIDTH) + 32'(rx_reg));

    // Walk step: the Bresenham error decides which axes advance.
    logic signed [CW:0]   e2;
    logic                 step_x, step_y;
    logic signed [CW-1:0] nx, ny;
    logic                 at_end, next_in_map, check_ok;
    logic signed [8:0]    cur_v;
    assign e2          = {err_reg, 1'b0};
    assign step_x      = e2 > -(CW + 1)'(dy_reg);
    assign step_y      = e2 < (CW + 1)'(dx_reg);
    assign nx          = step_x ? (sxn_reg ? x_reg - CW'(1) : x_reg + CW'(1)) : x_reg;
    assign ny          = step_y ? (syn_reg ? y_reg - CW'(1) : y_reg + CW'(1)) : y_reg;
    assign at_end      = (x_reg == x1_reg) && (y_reg == y1_reg);
    assign next_in_map = coord_in_map(nx, MAP_WIDTH) && coord_in_map(ny, MAP_HEIGHT);
    assign cur_v       = (mem_q_reg == CELL_UNKNOWN) ? UNKNOWN_AS : 9'(mem_q_reg);
    assign check_ok    = cell_in_map(cell_reg[0], MAP_WIDTH)
                      && cell_in_map(cell_reg[1], MAP_HEIGHT)
                      && cell_in_map(cell_reg[2], MAP_WIDTH)
                      && cell_in_map(cell_reg[3], MAP_HEIGHT);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                if (cmd_reg)
                begin
                    state_next = ST_READ_ADDR;
                end
                else if (invalid_reg || (range_reg < MIN_RANGE)
                         || (32'(beam_reg) >= 32'(MAX_BEAMS)))
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_ANGLE;
                end
            end
            ST_READ_ADDR: state_next = ST_READ_DATA;
            ST_READ_DATA: state_next = ST_FINISH;
            ST_ANGLE:     state_next = ST_ANGLE_SUM;
            ST_ANGLE_SUM: state_next = ST_SQ;
            ST_SQ:        state_next = ST_T1;
            ST_T1:        state_next = ST_T2;
            ST_T2:        state_next = ST_T3;
            ST_T3:        state_next = ST_T4;
            ST_T4:        state_next = ST_T5;
            ST_T5:        state_next = axis_reg ? ST_CELL_MUL : ST_SQ;
            ST_CELL_MUL:  state_next = ST_CELL_RES;
            ST_CELL_RES:  state_next = (cidx_reg == 2'd3) ? ST_CHECK : ST_CELL_MUL;
            ST_CHECK:     state_next = check_ok ? ST_WALK_RD : ST_FINISH;
            ST_WALK_RD:   state_next = ST_WALK_WR;
            ST_WALK_WR:
            begin
                if (at_end || !next_in_map)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_WALK_RD;
                end
            end
            ST_FINISH:    state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // Datapath, memory and multiplier control.
    always_comb
    begin
        logic signed [MUL_P_W-1:0] quo;
        logic signed [15:0]        sv;
        logic signed [15:0]        dval;
        logic signed [24:0]        pos;
        logic signed [23:0]        org;
        logic signed [8:0]         nv;
        logic signed [CW-1:0]      x0, y0, xe, ye;

        quo  = '0;
        sv   = '0;
        dval = '0;
        pos  = '0;
        org  = '0;
        nv   = '0;
        x0   = cell_reg[0][CW-1:0];
        y0   = cell_reg[1][CW-1:0];
        xe   = cell_reg[2][CW-1:0];
        ye   = cell_reg[3][CW-1:0];

        done_next     = 1'b0;
        range_next    = range_reg;
        ang_next      = ang_reg;
        axis_next     = axis_reg;
        x2_next       = x2_reg;
        hx_next       = hx_reg;
        hy_next       = hy_reg;
        cidx_next     = cidx_reg;
        cell_next     = cell_reg;
        hit_next      = hit_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        x1_next       = x1_reg;
        y1_next       = y1_reg;
        dx_next       = dx_reg;
        dy_next       = dy_reg;
        err_next      = err_reg;
        sxn_next      = sxn_reg;
        syn_next      = syn_reg;
        addr_next     = addr_reg;
        res_cell_next = res_cell_reg;
        count_next    = count_reg;
        marked_next   = marked_reg;
        traced_next   = traced_reg;

        mem_we  = 1'b0;
        mem_wa  = addr_reg;
        mem_wd  = '0;
        mem_ra  = addr_reg;
        mul_req = '0;

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we = 1'b1;
                mem_wa = clr_reg;
                mem_wd = CELL_UNKNOWN;
            end
            ST_DISPATCH:
            begin
                res_cell_next = '0;
                count_next    = '0;
                marked_next   = 1'b0;
                traced_next   = 1'b0;
                if (range_reg >= RANGE_CLAMP)
                begin
                    range_next = RANGE_CLAMP;
                    hit_next   = 1'b0;
                end
                else
                begin
                    hit_next = 1'b1;
                end
            end
            ST_READ_ADDR:
            begin
                mem_ra = rd_addr;
            end
            ST_READ_DATA:
            begin
                res_cell_next = rd_in_map ? mem_q_reg : CELL_UNKNOWN;
            end
            ST_ANGLE:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = MUL_A_W'($signed({1'b0, beam_reg}));
                mul_req.b  = MUL_B_W'($signed(ang_step_reg));
            end
            ST_ANGLE_SUM:
            begin
                ang_next  = (heading_reg + ang_start_reg + prod[15:0]) & ANG_MASK;
                axis_next = 1'b0;
            end
            ST_SQ:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = MUL_A_W'($signed({1'b0, q}));
                mul_req.b  = MUL_B_W'($signed({1'b0, q}));
            end
            ST_T1:
            begin
                x2_next    = prod_sh14[14:0];
                mul_req.en = 1'b1;
                mul_req.a  = MUL_A_W'($signed({1'b0, SIN_C1}));
                mul_req.b  = MUL_B_W'($signed({1'b0, prod_sh14[14:0]}));
            end
            ST_T2:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = MUL_A_W'($signed({1'b0, SIN_C2 - prod_sh14[14:0]}));
                mul_req.b  = MUL_B_W'($signed({1'b0, x2_reg}));
            end
            ST_T3:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = MUL_A_W'($signed({1'b0, q}));
                mul_req.b  = MUL_B_W'($signed({1'b0, SIN_C3 - prod_sh14[14:0]}));
            end
            ST_T4:
            begin
                sv         = quad[1] ? -prod_sh14[15:0] : prod_sh14[15:0];
                mul_req.en = 1'b1;
                mul_req.a  = MUL_A_W'($signed({1'b0, range_reg}));
                mul_req.b  = MUL_B_W'(sv);
            end
            ST_T5:
            begin
                quo  = div_pow2_trunc(prod, 14);
                dval = quo[15:0];
                if (axis_reg)
                begin
                    hy_next = 25'(pose_y_reg) + 25'(dval);
                end
                else
                begin
                    hx_next = 25'(pose_x_reg) + 25'(dval);
                end
                axis_next = 1'b1;
                cidx_next = 2'd0;
            end
            ST_CELL_MUL:
            begin
                case (cidx_reg)
                    2'd0:    pos = 25'(pose_x_reg);
                    2'd1:    pos = 25'(pose_y_reg);
                    2'd2:    pos = hx_reg;
                    default: pos = hy_reg;
                endcase
                org        = cidx_reg[0] ? origin_y_reg : origin_x_reg;
                mul_req.en = 1'b1;
                mul_req.a  = MUL_A_W'(pos) - MUL_A_W'(org);
                mul_req.b  = MUL_B_W'($signed({1'b0, cpm_reg}));
            end
            ST_CELL_RES:
            begin
                quo                 = div_pow2_trunc(prod, 18);
                cell_next[cidx_reg] = quo[25:0];
                cidx_next           = cidx_reg + 2'd1;
            end
            ST_CHECK:
            begin
                x_next   = x0;
                y_next   = y0;
                x1_next  = xe;
                y1_next  = ye;
                dx_next  = (xe > x0) ? xe - x0 : x0 - xe;
                dy_next  = (ye > y0) ? ye - y0 : y0 - ye;
                err_next = ((xe > x0) ? xe - x0 : x0 - xe) - ((ye > y0) ? ye - y0 : y0 - ye);
                sxn_next = !(x0 < xe);
                syn_next = !(y0 < ye);
                addr_next = AW'(32'(y0) * 32'(MAP_WIDTH) + 32'(x0));
            end
            ST_WALK_WR:
            begin
                if (at_end)
                begin
                    traced_next = 1'b1;
                    if (hit_reg)
                    begin
                        nv          = cur_v + 9'($signed({2'b0, occ_inc_reg}));
                        mem_we      = 1'b1;
                        mem_wd      = (nv > OCC_MAX) ? OCC_MAX[7:0] : nv[7:0];
                        count_next  = count_reg + 9'd1;
                        marked_next = 1'b1;
                    end
                end
                else
                begin
                    nv         = cur_v - 9'($signed({2'b0, free_dec_reg}));
                    mem_we     = 1'b1;
                    mem_wd     = (nv < OCC_MIN) ? OCC_MIN[7:0] : nv[7:0];
                    count_next = count_reg + 9'd1;
                    x_next     = nx;
                    y_next     = ny;
                    err_next   = err_reg - (step_x ? dy_reg : CW'(0))
                                         + (step_y ? dx_reg : CW'(0));
                    addr_next  = addr_reg
                               + (step_x ? (sxn_reg ? {AW{1'b1}} : AW'(1)) : AW'(0))
                               + (step_y ? (syn_reg ? AW'(0) - AW'(MAP_WIDTH)
                                                    : AW'(MAP_WIDTH)) : AW'(0));
                    if (!next_in_map)
                    begin
                        traced_next = 1'b1;
                    end
                end
            end
            ST_FINISH:
            begin
                done_next = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // Control registers and configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            done_reg      <= 1'b0;
            cpm_reg       <= 16'd5120;
            origin_x_reg  <= '0;
            origin_y_reg  <= '0;
            ang_start_reg <= 16'h8000;
            ang_step_reg  <= 16'd182;
            occ_inc_reg   <= 7'd25;
            free_dec_reg  <= 7'd10;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_reg <= clr_reg + AW'(1);
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_CELLS_PER_METRE: cpm_reg       <= cfg_data[15:0];
                    CFG_ORIGIN_X:        origin_x_reg  <= cfg_data;
                    CFG_ORIGIN_Y:        origin_y_reg  <= cfg_data;
                    CFG_ANGLE_START:     ang_start_reg <= cfg_data[15:0];
                    CFG_ANGLE_STEP:      ang_step_reg  <= cfg_data[15:0];
                    CFG_OCC_INCREMENT:   occ_inc_reg   <= cfg_data[6:0];
                    CFG_FREE_DECREMENT:  free_dec_reg  <= cfg_data[6:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start)
        begin
            cmd_reg     <= cmd;
            pose_x_reg  <= pose_x;
            pose_y_reg  <= pose_y;
            heading_reg <= pose_heading;
            invalid_reg <= range_invalid;
            beam_reg    <= beam_index;
            rx_reg      <= read_x;
            ry_reg      <= read_y;
            range_reg   <= beam_range;
        end
        else
        begin
            range_reg <= range_next;
        end
        ang_reg      <= ang_next;
        axis_reg     <= axis_next;
        x2_reg       <= x2_next;
        hx_reg       <= hx_next;
        hy_reg       <= hy_next;
        cidx_reg     <= cidx_next;
        cell_reg     <= cell_next;
        hit_reg      <= hit_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        x1_reg       <= x1_next;
        y1_reg       <= y1_next;
        dx_reg       <= dx_next;
        dy_reg       <= dy_next;
        err_reg      <= err_next;
        sxn_reg      <= sxn_next;
        syn_reg      <= syn_next;
        addr_reg     <= addr_next;
        res_cell_reg <= res_cell_next;
        count_reg    <= count_next;
        marked_reg   <= marked_next;
        traced_reg   <= traced_next;
    end

    // Grid memory: one write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            grid_mem[mem_wa] <= mem_wd;
        end
        mem_q_reg <= grid_mem[mem_ra];
    end

    assign done            = done_reg;
    assign cell_value      = res_cell_reg;
    assign cells_updated   = count_reg;
    assign endpoint_marked = marked_reg;
    assign beam_traced     = traced_reg;

    // Every result beat closes a sequence that went through the final state.
    a_done_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_FINISH))
        else $error("result beat without a finished sequence");

    // An accepted command keeps the core busy on the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not start the sequencer");

    // A marked endpoint only comes from a traced beam.
    a_marked_traced: assert property (@(posedge clk) disable iff (!rst_n)
        (done && endpoint_marked) |-> beam_traced)
        else $error("endpoint marked on an untraced beam");

endmodule
`default_nettype wire

@@ rtl/ogru_mul.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ogru_mul: shared signed multiplier
// One signed multiply per request, with the product registered for the
// next step of the sequencer.
// ---------------------------------------------------------------------------
module ogru_mul
    import ogru_pkg::*;
(
    input  wire logic                      clk,
    input  wire mul_req_t                  req,
    output logic signed [MUL_P_W-1:0]      prod
);

    logic signed [MUL_P_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            prod_reg <= MUL_P_W'(req.a) * MUL_P_W'(req.b);
        end
    end

    assign prod = prod_reg;

endmodule
`default_nettype wire

@@ verif/occupancy_grid_ray_update_core_test.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// occupancy_grid_ray_update_core_test: self-checking bench for the ray core
// Drives beam and read commands through the start/busy handshake; checks
// every done beat against the behavioral grid mapper here or a typed value.
// The register set is reprogrammed between phases while the core is idle.
// ---------------------------------------------------------------------------
module occupancy_grid_ray_update_core_test;
    import ogru_pkg::*;

    // Register index that the core decodes to nothing; writes must be ignored.
    localparam logic [2:0] CFG_UNUSED_INDEX = 3'd7;
    localparam int WATCHDOG_LIMIT = 400000;
    localparam int DRAIN_CYCLES   = 600;
    localparam int PHASE_ITEMS    = 205;

    typedef struct packed {
        logic               cmd;
        logic signed [23:0] pose_x;
        logic signed [23:0] pose_y;
        logic [15:0]        pose_heading;
        logic [15:0]        beam_range;
        logic               range_invalid;
        logic [10:0]        beam_index;
        logic [7:0]         read_x;
        logic [7:0]         read_y;
    } beam_cmd_t;

    typedef struct packed {
        logic signed [7:0] cell_value;
        logic [8:0]        cells_updated;
        logic              endpoint_marked;
        logic              beam_traced;
    } beam_result_t;

    // One row of the directed table: the command, and, where the outcome is
    // obvious, the result typed in by hand.
    typedef struct packed {
        beam_cmd_t    item;
        logic         typed;
        beam_result_t want;
    } directed_row_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic               cmd;
    logic signed [23:0] pose_x;
    logic signed [23:0] pose_y;
    logic [15:0]        pose_heading;
    logic [15:0]        beam_range;
    logic               range_invalid;
    logic [10:0]        beam_index;
    logic [7:0]         read_x;
    logic [7:0]         read_y;
    logic               done;
    logic signed [7:0]  cell_value;
    logic [8:0]         cells_updated;
    logic               endpoint_marked;
    logic               beam_traced;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_index;
    logic [23:0]        cfg_data;

    // Shadow copy of the occupancy grid and of the register file.
    logic signed [7:0] grid_shadow [0:65535];
    logic [15:0]       cells_per_metre_q;
    logic [23:0]       origin_x_q;
    logic [23:0]       origin_y_q;
    logic [15:0]       angle_start_q;
    logic [15:0]       angle_step_q;
    logic [6:0]        occ_increment_q;
    logic [6:0]        free_decrement_q;

    beam_result_t pending_results [$];
    int           error_count;
    int           idle_cycles;

    occupancy_grid_ray_update_core uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .cmd             (cmd),
        .pose_x          (pose_x),
        .pose_y          (pose_y),
        .pose_heading    (pose_heading),
        .beam_range      (beam_range),
        .range_invalid   (range_invalid),
        .beam_index      (beam_index),
        .read_x          (read_x),
        .read_y          (read_y),
        .done            (done),
        .cell_value      (cell_value),
        .cells_updated   (cells_updated),
        .endpoint_marked (endpoint_marked),
        .beam_traced     (beam_traced),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    task automatic report(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Polynomial sine on one quarter wave, Q14 in and out.
    function automatic longint quarter_sine(input longint q);
        longint sq;
        longint t;
        longint v;
        sq = (q * q) >>> 14;
        t  = (1231 * sq) >>> 14;
        v  = ((10583 - t) * sq) >>> 14;
        return (q * (25736 - v)) >>> 14;
    endfunction

    // Full-turn sine of a 16-bit binary angle, mirrored and negated by quadrant.
    function automatic longint binary_angle_sine(input logic [15:0] a);
        longint r;
        longint s;
        r = longint'(a[13:0]);
        s = a[14] ? quarter_sine(16384 - r) : quarter_sine(r);
        return a[15] ? -s : s;
    endfunction

    // Metric position to grid cell; the division truncates toward zero.
    function automatic longint metric_to_cell(input longint pos, input longint origin);
        return ((pos - origin) * longint'(cells_per_metre_q)) / 262144;
    endfunction

    function automatic bit cell_on_map(input longint x, input longint y);
        return x >= 0 && x < MAP_WIDTH_DEF && y >= 0 && y < MAP_HEIGHT_DEF;
    endfunction

    // Computes the result of one command and applies its grid updates.
    function automatic beam_result_t predict_grid_result(input beam_cmd_t it);
        beam_result_t r;
        longint rng;
        longint px;
        longint py;
        longint ox;
        longint oy;
        longint x0;
        longint y0;
        longint x1;
        longint y1;
        longint dx;
        longint dy;
        longint sx;
        longint sy;
        longint err;
        longint e2;
        longint x;
        longint y;
        longint v;
        logic [31:0] ang_sum;
        logic [15:0] ang;
        bit hit;
        int count;
        bit marked;
        r = '0;
        hit = 1'b1;
        count = 0;
        marked = 1'b0;
        if (it.cmd)
        begin
            r.cell_value = grid_shadow[{it.read_y, it.read_x}];
            return r;
        end
        rng = longint'(it.beam_range);
        if (it.range_invalid || rng < longint'(MIN_RANGE) || it.beam_index >= MAX_BEAMS_DEF)
            return r;
        if (rng >= longint'(RANGE_CLAMP))
        begin
            rng = longint'(RANGE_CLAMP);
            hit = 1'b0;
        end
        px = longint'(it.pose_x);
        py = longint'(it.pose_y);
        ox = longint'($signed(origin_x_q));
        oy = longint'($signed(origin_y_q));
        ang_sum = 32'(it.pose_heading) + 32'(angle_start_q)
                + 32'(it.beam_index) * 32'(angle_step_q);
        ang = ang_sum[15:0];
        ang = (ang >> (16 - TRIG_BITS_DEF)) << (16 - TRIG_BITS_DEF);
        x0 = metric_to_cell(px, ox);
        y0 = metric_to_cell(py, oy);
        x1 = metric_to_cell(px + (rng * binary_angle_sine(ang + 16'h4000)) / 16384, ox);
        y1 = metric_to_cell(py + (rng * binary_angle_sine(ang)) / 16384, oy);
        if (!cell_on_map(x0, y0) || !cell_on_map(x1, y1))
            return r;
        dx = x1 > x0 ? x1 - x0 : x0 - x1;
        dy = y1 > y0 ? y1 - y0 : y0 - y1;
        sx = x0 < x1 ? 1 : -1;
        sy = y0 < y1 ? 1 : -1;
        err = dx - dy;
        x = x0;
        y = y0;
        while (1)
        begin
            v = longint'(grid_shadow[y * MAP_WIDTH_DEF + x]);
            if (v == -1)
                v = 50;
            if (x == x1 && y == y1)
            begin
                if (hit)
                begin
                    v = v + longint'(occ_increment_q);
                    if (v > 100)
                        v = 100;
                    grid_shadow[y * MAP_WIDTH_DEF + x] = 8'(v);
                    count++;
                    marked = 1'b1;
                end
                break;
            end
            v = v - longint'(free_decrement_q);
            if (v < 0)
                v = 0;
            grid_shadow[y * MAP_WIDTH_DEF + x] = 8'(v);
            count++;
            e2 = 2 * err;
            if (e2 > -dy)
            begin
                err -= dy;
                x += sx;
            end
            if (e2 < dx)
            begin
                err += dx;
                y += sy;
            end
            if (!cell_on_map(x, y))
                break;
        end
        r.cells_updated   = 9'(count);
        r.endpoint_marked = marked;
        r.beam_traced     = 1'b1;
        return r;
    endfunction

    // Drives one command and waits for the edge that accepts it. The
    // expectation is queued at that edge, from the typed value if given.
    task automatic send_command(input beam_cmd_t it, input bit typed, input beam_result_t want);
        beam_result_t predicted;
        @(negedge clk);
        start         = 1'b1;
        cmd           = it.cmd;
        pose_x        = it.pose_x;
        pose_y        = it.pose_y;
        pose_heading  = it.pose_heading;
        beam_range    = it.beam_range;
        range_invalid = it.range_invalid;
        beam_index    = it.beam_index;
        read_x        = it.read_x;
        read_y        = it.read_y;
        do
            @(posedge clk);
        while (busy);
        predicted = predict_grid_result(it);
        pending_results.push_back(typed ? want : predicted);
    endtask

    task automatic hold_off(input int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            start = 1'b0;
        end
    endtask

    task automatic write_register(input logic [2:0] idx, input logic [23:0] value);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_CELLS_PER_METRE: cells_per_metre_q = value[15:0];
            CFG_ORIGIN_X:        origin_x_q        = value;
            CFG_ORIGIN_Y:        origin_y_q        = value;
            CFG_ANGLE_START:     angle_start_q     = value[15:0];
            CFG_ANGLE_STEP:      angle_step_q      = value[15:0];
            CFG_OCC_INCREMENT:   occ_increment_q   = value[6:0];
            CFG_FREE_DECREMENT:  free_decrement_q  = value[6:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Waits until every queued result has come back, so that the core is idle.
    task automatic wait_for_drain();
        hold_off(1);
        while (pending_results.size() != 0)
            @(posedge clk);
        hold_off(2);
    endtask

    task automatic program_setting(input logic [15:0] cpm, input logic [23:0] ox,
                                   input logic [23:0] oy, input logic [15:0] a0,
                                   input logic [15:0] astep, input logic [6:0] inc,
                                   input logic [6:0] dec);
        wait_for_drain();
        write_register(CFG_CELLS_PER_METRE, {8'h00, cpm});
        write_register(CFG_ORIGIN_X, ox);
        write_register(CFG_ORIGIN_Y, oy);
        write_register(CFG_ANGLE_START, {8'hA5, a0});
        write_register(CFG_ANGLE_STEP, {8'h5A, astep});
        write_register(CFG_OCC_INCREMENT, {17'h1FFFF, inc});
        write_register(CFG_FREE_DECREMENT, {17'h0, dec});
    endtask

    // Builds a random command. Most are beams from inside the mapped area, so
    // that walks actually touch the grid; some are reads and a few are noise.
    function automatic beam_cmd_t random_command();
        beam_cmd_t it;
        longint span;
        int pick;
        it = '0;
        it.pose_heading = 16'($urandom);
        it.beam_index   = 11'($urandom);
        it.read_x       = 8'($urandom);
        it.read_y       = 8'($urandom);
        span = (longint'(MAP_WIDTH_DEF) * 262144) / longint'(cells_per_metre_q) - 1;
        if (span > 4000000)
            span = 4000000;
        it.pose_x = 24'(longint'($signed(origin_x_q)) + longint'($urandom_range(0, 32'(span))));
        it.pose_y = 24'(longint'($signed(origin_y_q)) + longint'($urandom_range(0, 32'(span))));
        pick = $urandom_range(0, 99);
        if (pick < 6)
        begin
            it = beam_cmd_t'({$urandom, $urandom, $urandom, $urandom});
        end
        else if (pick < 38)
        begin
            it.cmd = 1'b1;
        end
        else
        begin
            pick = $urandom_range(0, 99);
            if (pick < 84)
                it.beam_range = 16'($urandom_range(MIN_RANGE, RANGE_CLAMP - 1));
            else if (pick < 92)
                it.beam_range = 16'($urandom_range(RANGE_CLAMP, 65535));
            else
                it.beam_range = 16'($urandom_range(0, MIN_RANGE - 1));
            it.range_invalid = ($urandom_range(0, 19) == 0);
        end
        return it;
    endfunction

    function automatic directed_row_t make_row(input logic c, input int px, input int py,
                                               input int hd, input int rg, input logic inv,
                                               input int bi, input int rx, input int ry,
                                               input logic typed, input int cv);
        directed_row_t row;
        row.item = '{cmd: c, pose_x: 24'(px), pose_y: 24'(py), pose_heading: 16'(hd),
                     beam_range: 16'(rg), range_invalid: inv, beam_index: 11'(bi),
                     read_x: 8'(rx), read_y: 8'(ry)};
        row.typed = typed;
        row.want  = '{cell_value: 8'(cv), cells_updated: '0, endpoint_marked: 1'b0,
                      beam_traced: 1'b0};
        return row;
    endfunction

    // Every done beat is matched against the oldest outstanding expectation.
    always @(posedge clk)
    begin
        beam_result_t exp_r;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                report("result beat with no command outstanding");
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (cell_value !== exp_r.cell_value)
                    report($sformatf("cell_value %0d, expected %0d",
                                     cell_value, exp_r.cell_value));
                if (cells_updated !== exp_r.cells_updated)
                    report($sformatf("cells_updated %0d, expected %0d",
                                     cells_updated, exp_r.cells_updated));
                if (endpoint_marked !== exp_r.endpoint_marked)
                    report($sformatf("endpoint_marked %0b, expected %0b",
                                     endpoint_marked, exp_r.endpoint_marked));
                if (beam_traced !== exp_r.beam_traced)
                    report($sformatf("beam_traced %0b, expected %0b",
                                     beam_traced, exp_r.beam_traced));
            end
        end
    end

    // The watchdog restarts on any accepted beat; the clearing pass after
    // reset fits well inside the limit.
    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        directed_row_t directed [$];
        beam_result_t  none;
        int burst_left;
        error_count   = 0;
        idle_cycles   = 0;
        rst_n         = 1'b0;
        start         = 1'b0;
        cmd           = 1'b0;
        pose_x        = '0;
        pose_y        = '0;
        pose_heading  = '0;
        beam_range    = '0;
        range_invalid = 1'b0;
        beam_index    = '0;
        read_x        = '0;
        read_y        = '0;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_CELLS_PER_METRE;
        cfg_data      = '0;
        none          = '0;
        for (int i = 0; i < 65536; i++)
            grid_shadow[i] = CELL_UNKNOWN;
        cells_per_metre_q = 16'd5120;
        origin_x_q        = '0;
        origin_y_q        = '0;
        angle_start_q     = 16'h8000;
        angle_step_q      = 16'd182;
        occ_increment_q   = 7'd25;
        free_decrement_q  = 7'd10;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part, at reset register values. With 20 cells per metre,
        // position 6553 sits in cell 127 on both axes.
        directed.push_back(make_row(1, 0, 0, 0, 0, 0, 0, 0, 0, 1, -1));
        directed.push_back(make_row(1, 0, 0, 0, 0, 0, 0, 255, 255, 1, -1));
        directed.push_back(make_row(0, 6553, 6553, 0, 5000, 1, 0, 0, 0, 1, 0));
        directed.push_back(make_row(0, 6553, 6553, 0, 51, 0, 0, 0, 0, 1, 0));
        directed.push_back(make_row(0, 6553, 6553, 0, 0, 0, 0, 0, 0, 1, 0));
        directed.push_back(make_row(0, -8388608, -8388608, 0, 1000, 0, 0, 0, 0, 1, 0));
        directed.push_back(make_row(0, 8388607, 8388607, 65535, 1000, 0, 0, 0, 0, 1, 0));
        directed.push_back(make_row(0, 6553, 6553, 0, 1000, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_row(0, 6553, 6553, 0, 52, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_row(0, 6553, 6553, 16384, 10240, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_row(0, 6553, 6553, 8000, 65535, 0, 1, 0, 0, 0, 0));
        directed.push_back(make_row(0, 6553, 6553, 65535, 3000, 0, 2047, 0, 0, 0, 0));
        for (int i = 0; i < 6; i++)
            directed.push_back(make_row(0, 6553, 6553, 40000, 800, 0, 5, 0, 0, 0, 0));
        directed.push_back(make_row(1, 0, 0, 0, 0, 0, 0, 127, 127, 0, 0));
        directed.push_back(make_row(1, -1, -1, 65535, 65535, 1, 2047, 128, 127, 0, 0));
        directed.push_back(make_row(1, 0, 0, 0, 0, 0, 0, 255, 0, 0, 0));
        foreach (directed[i])
            send_command(directed[i].item, directed[i].typed, directed[i].want);

        // Random phases, each under its own register setting; extreme values of
        // several registers are visited, including increments and decrements above 100.
        burst_left = 0;
        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                1: program_setting(16'd65535, 24'd0, 24'd0, 16'd0, 16'd1, 7'd100, 7'd100);
                2: program_setting(16'd1, 24'h800000, 24'h800000, 16'h7FFF, 16'h8000,
                                   7'd0, 7'd0);
                3: program_setting(16'd2560, 24'(-100000), 24'(-50000), 16'h8000,
                                   16'h7FFF, 7'd127, 7'd127);
                4:
                begin
                    program_setting(16'($urandom_range(256, 12000)), 24'(-$urandom_range(0, 5000)),
                                    24'($urandom_range(0, 5000)), 16'($urandom),
                                    16'($urandom), 7'($urandom_range(0, 100)),
                                    7'($urandom_range(0, 100)));
                    write_register(CFG_UNUSED_INDEX, 24'($urandom));
                end
                default: ;
            endcase
            repeat (PHASE_ITEMS)
            begin
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 30);
                    if ($urandom_range(0, 2) != 0)
                        hold_off($urandom_range(1, 20));
                end
                burst_left--;
                send_command(random_command(), 1'b0, none);
            end
        end

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ occupancy_grid_ray_update_core.f @@
rtl/ogru_pkg.sv
rtl/ogru_mul.sv
rtl/occupancy_grid_ray_update_core.sv
verif/occupancy_grid_ray_update_core_test.sv
